FILE: sv/btem_pkg.sv
// Shared types and constants for the binary threshold edge map.
`default_nettype none

package btem_pkg;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 7;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 8'd128;
    localparam int GEOM_RESET = 120;

    typedef struct packed {
        logic               frame_done;
        logic               last_of_run;
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
        logic               edge_bit;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/btem_in_reg.sv
// Input register: holds one accepted grey pixel until the processing step takes it.
`default_nettype none

module btem_in_reg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,   // [7:0] grey_pixel
    input  wire logic                      take,
    output logic                           pix_valid,
    output logic [btem_pkg::PIX_W-1:0]     pix_grey
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [btem_pkg::PIX_W-1:0]    grey_reg;

    assign s_tready  = !valid_reg || take;
    assign pix_valid = valid_reg;
    assign pix_grey  = grey_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            grey_reg <= s_tdata;
        end
    end

endmodule

`default_nettype wire

FILE: sv/btem_line_buf.sv
// One-row line buffer of binary bits, kept as a rotating shift line with fixed read taps.
`default_nettype none

module btem_line_buf #(
    parameter int MAX_WIDTH = 128,
    parameter int IW        = 7
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          shift_en,
    input  wire logic [IW-1:0] insert_idx,
    input  wire logic          bit_in,
    output logic               above,
    output logic               above_right
);

    // line_reg[k] holds the bit for column (col + k) mod width of the stored row
    logic [MAX_WIDTH-1:0] line_reg;
    logic [MAX_WIDTH-1:0] line_next;

    assign above       = line_reg[0];
    assign above_right = line_reg[1];

    always_comb
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            if (IW'(i) == insert_idx)
            begin
                line_next[i] = bit_in;
            end
            else if (i + 1 < MAX_WIDTH)
            begin
                line_next[i] = line_reg[(i + 1) % MAX_WIDTH];
            end
            else
            begin
                line_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= '0;
        end
        else if (shift_en)
        begin
            line_reg <= line_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/btem_out_queue.sv
// Two-entry result queue: takes up to two results a cycle, presents one a cycle.
`default_nettype none

module btem_out_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [1:0]        push_n,
    input  wire btem_pkg::result_t res0,
    input  wire btem_pkg::result_t res1,
    output logic [1:0]             space,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output btem_pkg::result_t      head
);

    btem_pkg::result_t slot_reg [2];
    btem_pkg::result_t slot_next [2];
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              pop;
    logic [1:0]        rem;

    assign m_tvalid = (count_reg != 2'd0);
    assign head     = slot_reg[0];
    assign pop      = m_tvalid && m_tready;
    assign rem      = count_reg - {1'b0, pop};
    assign space    = 2'd2 - rem;

    always_comb
    begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        case (rem)
            2'd0:
            begin
                slot_next[0] = res0;
                slot_next[1] = res1;
            end
            2'd1:
            begin
                slot_next[0] = pop ? slot_reg[1] : slot_reg[0];
                slot_next[1] = res0;
            end
            default:
            begin
                slot_next[0] = slot_reg[0];
                slot_next[1] = slot_reg[1];
            end
        endcase
        count_next = rem + push_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("result queue count out of range");

    assert property (@(posedge clk) disable iff (!rst_n) push_n <= space)
        else $error("result queue overflow");

endmodule

`default_nettype wire

FILE: sv/binary_threshold_edge_map.sv
// Top level of the binary threshold edge map: configuration, position counters, edge logic.
// Usage:
//  Input stream s_*: one grey pixel per transaction, frame in row-major order.
//  Output stream m_*: results; tdata carries edge_bit, out_row and out_col, tlast marks
//  the final result caused by one pixel and tuser flags the frame's last pixel.
//  A pixel of row r yields the result for row r-1 at the same column; pixels of the
//  last row yield that result and then their own. The first row yields nothing.
//  Each pixel is registered in the input register and its results in the result queue
//  before they are offered. Throughput: one pixel per cycle while the receiver keeps up;
//  in the last row the output port carries two results per pixel, so each pixel there waits for queue room for both.
//  The input register frees itself whenever the two-entry result queue has room, so
//  a stalled receiver holds up to two results plus one pending pixel before s_tready
//  falls.
//  Configuration writes on cfg_* take effect at once and are meant for idle periods;
//  writing the width or height restarts the frame at row 0, column 0.
//  Reset: threshold 128, width and height 120 (width limited to MAX_WIDTH), line buffer
//  cleared, position at the frame start, no results pending.
`default_nettype none

module binary_threshold_edge_map #(
    parameter int MAX_WIDTH = 128
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] grey_pixel
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [15:0]     m_tdata,   // [0] edge_bit, [7:1] out_row, [14:8] out_col
    output logic            m_tlast,   // last_of_run
    output logic            m_tuser    // frame_done
);

    localparam int IW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int W_RESET = (btem_pkg::GEOM_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                : btem_pkg::GEOM_RESET;
    localparam logic [IW-1:0] W_M1_RESET = IW'(W_RESET - 1);
    localparam logic [IW-1:0] W_M1_MAX   = IW'(MAX_WIDTH - 1);
    localparam logic [btem_pkg::COORD_W-1:0] H_M1_RESET =
        btem_pkg::COORD_W'(btem_pkg::GEOM_RESET - 1);

    logic [btem_pkg::CFG_W-1:0]   threshold_reg;
    logic [IW-1:0]                w_m1_reg;
    logic [IW-1:0]                w_m1_next;
    logic [btem_pkg::COORD_W-1:0] h_m1_reg;
    logic [btem_pkg::COORD_W-1:0] h_m1_next;
    logic [IW-1:0]                col_reg;
    logic [IW-1:0]                col_next;
    logic [btem_pkg::COORD_W-1:0] row_reg;
    logic [btem_pkg::COORD_W-1:0] row_next;

    logic                         pix_valid;
    logic [btem_pkg::PIX_W-1:0]   pix_grey;
    logic                         proc_fire;
    logic                         bin_bit;
    logic                         above;
    logic                         above_right;
    logic                         has_above;
    logic                         last_row;
    logic                         last_col;
    logic                         edge_val;
    logic [1:0]                   res_n;
    logic [1:0]                   push_n;
    logic [1:0]                   space;
    logic                         geom_write;
    btem_pkg::result_t            res_above;
    btem_pkg::result_t            res_own;
    btem_pkg::result_t            res0;
    btem_pkg::result_t            head;

    btem_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .take      (proc_fire),
        .pix_valid (pix_valid),
        .pix_grey  (pix_grey)
    );

    btem_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .IW        (IW)
    ) u_line_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .shift_en    (proc_fire),
        .insert_idx  (w_m1_reg),
        .bit_in      (bin_bit),
        .above       (above),
        .above_right (above_right)
    );

    // Clamp geometry at write time so the datapath sees only legal last indexes
    always_comb
    begin
        if (cfg_data < 8'd2)
        begin
            w_m1_next = IW'(1);
        end
        else if (int'(cfg_data) > MAX_WIDTH)
        begin
            w_m1_next = W_M1_MAX;
        end
        else
        begin
            w_m1_next = IW'(cfg_data - 8'd1);
        end

        if (cfg_data < 8'd2)
        begin
            h_m1_next = btem_pkg::COORD_W'(1);
        end
        else if (cfg_data[7])
        begin
            h_m1_next = {btem_pkg::COORD_W{1'b1}};
        end
        else
        begin
            h_m1_next = btem_pkg::COORD_W'(cfg_data - 8'd1);
        end
    end

    assign geom_write = cfg_wr_en && ((cfg_index == btem_pkg::REG_IMAGE_WIDTH) ||
                                      (cfg_index == btem_pkg::REG_IMAGE_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= btem_pkg::THRESHOLD_RESET;
            w_m1_reg      <= W_M1_RESET;
            h_m1_reg      <= H_M1_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                btem_pkg::REG_THRESHOLD:    threshold_reg <= cfg_data;
                btem_pkg::REG_IMAGE_WIDTH:  w_m1_reg      <= w_m1_next;
                btem_pkg::REG_IMAGE_HEIGHT: h_m1_reg      <= h_m1_next;
                default:                    threshold_reg <= threshold_reg;
            endcase
        end
    end

    // Binarise and form the edge bit against the stored row
    assign bin_bit   = (pix_grey >= threshold_reg);
    assign has_above = (row_reg != '0);
    assign last_row  = (row_reg == h_m1_reg);
    assign last_col  = (col_reg == w_m1_reg);
    assign edge_val  = last_col ? above : ((above ^ bin_bit) | (above ^ above_right));
    assign res_n     = {1'b0, has_above} + {1'b0, last_row};
    assign proc_fire = pix_valid && (res_n <= space);
    assign push_n    = proc_fire ? res_n : 2'd0;

    always_comb
    begin
        res_above.edge_bit    = edge_val;
        res_above.out_row     = row_reg - btem_pkg::COORD_W'(1);
        res_above.out_col     = btem_pkg::COORD_W'(col_reg);
        res_above.last_of_run = !last_row;
        res_above.frame_done  = 1'b0;

        res_own.edge_bit      = bin_bit;
        res_own.out_row       = row_reg;
        res_own.out_col       = btem_pkg::COORD_W'(col_reg);
        res_own.last_of_run   = 1'b1;
        res_own.frame_done    = last_col;

        res0 = has_above ? res_above : res_own;
    end

    // Advance the frame position; a geometry write restarts the frame
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (geom_write)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (proc_fire)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + btem_pkg::COORD_W'(1);
            end
            else
            begin
                col_next = col_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    btem_out_queue u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_n   (push_n),
        .res0     (res0),
        .res1     (res_own),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    assign m_tdata = {1'b0, head.out_col, head.out_row, head.edge_bit};
    assign m_tlast = head.last_of_run;
    assign m_tuser = head.frame_done;

    assert property (@(posedge clk) disable iff (!rst_n) m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end result not marked last of run");

    assert property (@(posedge clk) disable iff (!rst_n)
                     geom_write |=> (col_reg == '0) && (row_reg == '0))
        else $error("geometry write did not restart the frame");

    assert property (@(posedge clk) disable iff (!rst_n)
                     proc_fire && (row_reg == '0) && !last_row |-> push_n == 2'd0)
        else $error("first row pixel produced a result");

    assert property (@(posedge clk) disable iff (!rst_n)
                     col_reg <= w_m1_reg && row_reg <= h_m1_reg)
        else $error("frame position beyond geometry");

endmodule

`default_nettype wire
